@@ rtl/core/esc_pkg.sv @@
package esc_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_CAL_TEMP    = 3'd0,
      CSR_CAL_PRESS_A = 3'd1,
      CSR_CAL_PRESS_B = 3'd2,
      CSR_CAL_MIXED   = 3'd3,
      CSR_CAL_HUM     = 3'd4
   } csr_index_type;

   localparam int DIV_STAGES = 64;

   localparam logic [63:0] PRESS_T_OFS  = 64'd128000;
   localparam logic [63:0] PRESS_ADC_FS = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE  = 64'd3125;
   localparam logic [63:0] PRESS_BIAS   = 64'h0000_8000_0000_0000;
   localparam logic [31:0] HUM_T_OFS    = 32'd76800;
   localparam logic [31:0] HUM_ROUND_A  = 32'd16384;
   localparam logic [31:0] HUM_OFS_B    = 32'd32768;
   localparam logic [31:0] HUM_OFS_D    = 32'd2097152;
   localparam logic [31:0] HUM_ROUND_E  = 32'd8192;
   localparam logic [31:0] HUM_MAX_ACC  = 32'd419430400;

   // results that ride along with the pressure division
   typedef struct packed {
      logic [15:0] temp;
      logic [16:0] hum;
      logic        azero;
      logic        negq;
   } side_type;

endpackage

@@ rtl/core/esc_mul64.sv @@
// low 64 bits of a 64 x 64 product, two register stages
module esc_mul64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0] ll_ff;
   logic [31:0] hl_ff, lh_ff;
   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= {32'b0, a[31:0]} * {32'b0, b[31:0]};
         hl_ff <= a[63:32] * b[31:0];
         lh_ff <= a[31:0] * b[63:32];
         p_ff  <= ll_ff + {hl_ff + lh_ff, 32'b0};
      end
   end

   assign p = p_ff;

endmodule

@@ rtl/core/esc_div.sv @@
// unsigned 64 / 64 restoring divider, one quotient bit per stage
module esc_div (
   input  logic              clock,
   input  logic              en,
   input  logic [63:0]       num,
   input  logic [63:0]       den,
   input  esc_pkg::side_type side_in,
   output logic [63:0]       quot,
   output esc_pkg::side_type side_out
);

   localparam int N = esc_pkg::DIV_STAGES;

   logic [63:0]       r_ff [1:N];
   logic [63:0]       n_ff [1:N];
   logic [63:0]       d_ff [1:N];
   esc_pkg::side_type s_ff [1:N];

   logic [63:0]       src_r [0:N-1];
   logic [63:0]       src_n [0:N-1];
   logic [63:0]       src_d [0:N-1];
   esc_pkg::side_type src_s [0:N-1];
   logic [63:0]       r_in  [0:N-1];
   logic [63:0]       n_in  [0:N-1];

   always_comb begin
      logic [64:0] trial;
      trial = '0;
      src_r[0] = '0;
      src_n[0] = num;
      src_d[0] = den;
      src_s[0] = side_in;
      for (int i = 1; i < N; i++) begin
         src_r[i] = r_ff[i];
         src_n[i] = n_ff[i];
         src_d[i] = d_ff[i];
         src_s[i] = s_ff[i];
      end
      for (int i = 0; i < N; i++) begin
         // shift in the next dividend bit, subtract when it fits
         trial = {src_r[i], src_n[i][63]};
         if (trial >= {1'b0, src_d[i]}) begin
            r_in[i] = 64'(trial - {1'b0, src_d[i]});
            n_in[i] = {src_n[i][62:0], 1'b1};
         end else begin
            r_in[i] = trial[63:0];
            n_in[i] = {src_n[i][62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            r_ff[i+1] <= r_in[i];
            n_ff[i+1] <= n_in[i];
            d_ff[i+1] <= src_d[i];
            s_ff[i+1] <= src_s[i];
         end
      end
   end

   assign quot     = n_ff[N];
   assign side_out = s_ff[N];

endmodule

@@ rtl/core/env_sensor_compensation_top.sv @@
// channel | direction | word
// req_    | in        | tdata: adc_pressure, adc_temperature, adc_humidity
// rsp_    | out       | tdata: temperature_centi, pressure_q24_8, humidity_q7_10;
//         |           | tuser: pressure_valid
// csr_    | in        | we, index, wdata (write only)
// One sample per cycle while the output is not stalled; the depth from accept to the output
// register is set mostly by the 64-stage pressure divider.
// Reset clears the calibration registers and all stage valid bits.
// A stalled output freezes the whole pipeline, so nothing is dropped or repeated.
module env_sensor_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // adc_pressure[19:0], adc_temperature[39:20],
                                   // adc_humidity[55:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // temperature_centi[15:0], pressure_q24_8[47:16],
                                   // humidity_q7_10[64:48], zero fill
   output logic        rsp_tuser,  // pressure_valid
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int LAT = 87;

   logic [47:0] cal_temp_ff;
   logic [63:0] cal_pa_ff, cal_pb_ff;
   logic [47:0] cal_mixed_ff;
   logic [31:0] cal_hum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff  <= '0;
         cal_pa_ff    <= '0;
         cal_pb_ff    <= '0;
         cal_mixed_ff <= '0;
         cal_hum_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            esc_pkg::CSR_CAL_TEMP:    cal_temp_ff  <= csr_wdata[47:0];
            esc_pkg::CSR_CAL_PRESS_A: cal_pa_ff    <= csr_wdata;
            esc_pkg::CSR_CAL_PRESS_B: cal_pb_ff    <= csr_wdata;
            esc_pkg::CSR_CAL_MIXED:   cal_mixed_ff <= csr_wdata[47:0];
            esc_pkg::CSR_CAL_HUM:     cal_hum_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // coefficients, extended to datapath width
   logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = {16'b0, cal_temp_ff[15:0]};
   assign t2 = {{16{cal_temp_ff[31]}}, cal_temp_ff[31:16]};
   assign t3 = {{16{cal_temp_ff[47]}}, cal_temp_ff[47:32]};
   assign p1 = {48'b0, cal_pa_ff[15:0]};
   assign p2 = {{48{cal_pa_ff[31]}}, cal_pa_ff[31:16]};
   assign p3 = {{48{cal_pa_ff[47]}}, cal_pa_ff[47:32]};
   assign p4 = {{48{cal_pa_ff[63]}}, cal_pa_ff[63:48]};
   assign p5 = {{48{cal_pb_ff[15]}}, cal_pb_ff[15:0]};
   assign p6 = {{48{cal_pb_ff[31]}}, cal_pb_ff[31:16]};
   assign p7 = {{48{cal_pb_ff[47]}}, cal_pb_ff[47:32]};
   assign p8 = {{48{cal_pb_ff[63]}}, cal_pb_ff[63:48]};
   assign p9 = {{48{cal_mixed_ff[15]}}, cal_mixed_ff[15:0]};
   assign h1 = {24'b0, cal_mixed_ff[23:16]};
   assign h2 = {{16{cal_mixed_ff[39]}}, cal_mixed_ff[39:24]};
   assign h3 = {24'b0, cal_mixed_ff[47:40]};
   assign h4 = {{20{cal_hum_ff[11]}}, cal_hum_ff[11:0]};
   assign h5 = {{20{cal_hum_ff[23]}}, cal_hum_ff[23:12]};
   assign h6 = {{24{cal_hum_ff[31]}}, cal_hum_ff[31:24]};

   // pipeline control
   logic adv;
   logic vld_ff [1:LAT];

   assign adv        = !vld_ff[LAT] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= LAT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_tvalid;
         for (int i = 2; i <= LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   logic [19:0] adc_p, adc_t;
   logic [15:0] adc_h;
   assign adc_p = req_tdata[19:0];
   assign adc_t = req_tdata[39:20];
   assign adc_h = req_tdata[55:40];

   // temperature front end, stages 1..5
   logic [31:0] d1_ff, d2_ff, m1_ff, m2_ff, var1_ff, m3_ff, tf_ff;
   logic [19:0] adcp_ff [1:4];
   logic [15:0] adch_ff [1:6];
   logic [31:0] tc_c;
   logic [15:0] temp_c;

   always_comb begin
      tc_c = 32'($signed((tf_ff << 2) + tf_ff + 32'd128) >>> 8);
      if (tc_c[31])
         temp_c = (tc_c < 32'hFFFF_8000) ? 16'h8000 : tc_c[15:0];
      else
         temp_c = (tc_c > 32'h0000_7FFF) ? 16'h7FFF : tc_c[15:0];
   end

   // humidity stages
   logic [31:0] v_ff, mh5v_ff, mvh3_ff, mvh6_ff, hb_ff, hc_ff, mhb_ff, hd_ff, mhd_ff;
   logic [31:0] he_ff, x12_ff, mss_ff, mt_ff;
   logic [31:0] ha_ff [7:11];
   logic [31:0] x_ff  [13:14];
   logic [16:0] hum_ff;
   logic [31:0] ha_c, s_c, x2_c, xc_c;

   always_comb begin
      ha_c = 32'($signed(({16'b0, adch_ff[6]} << 14) - (h4 << 20) - mh5v_ff
                         + esc_pkg::HUM_ROUND_A) >>> 15);
      s_c  = 32'($signed(x12_ff) >>> 15);
      x2_c = x_ff[14] - 32'($signed(mt_ff) >>> 4);
      if (x2_c[31])
         xc_c = '0;
      else if (x2_c > esc_pkg::HUM_MAX_ACC)
         xc_c = esc_pkg::HUM_MAX_ACC;
      else
         xc_c = x2_c;
   end

   // pressure front end
   logic [63:0] a0_ff, b_ff, a2x_ff, bigA_ff, t_ff;
   logic [63:0] pn_ff [5:12];
   logic [63:0] ap5_ff [8:9];
   logic [63:0] ap2_ff [8:9];
   logic [63:0] bd_ff [11:12];
   logic [63:0] ad_ff [14:15];
   logic [15:0] temp_ff [5:15];
   logic [63:0] aa_w, ap5_w, ap2_w, b1_w, c1_w, a3_w, num_w;

   esc_mul64 u_mul_aa  (.clock, .en(adv), .a(a0_ff),  .b(a0_ff), .p(aa_w));
   esc_mul64 u_mul_ap5 (.clock, .en(adv), .a(a0_ff),  .b(p5),    .p(ap5_w));
   esc_mul64 u_mul_ap2 (.clock, .en(adv), .a(a0_ff),  .b(p2),    .p(ap2_w));
   esc_mul64 u_mul_b1  (.clock, .en(adv), .a(aa_w),   .b(p6),    .p(b1_w));
   esc_mul64 u_mul_c1  (.clock, .en(adv), .a(aa_w),   .b(p3),    .p(c1_w));
   esc_mul64 u_mul_a3  (.clock, .en(adv), .a(a2x_ff), .b(p1),    .p(a3_w));
   esc_mul64 u_mul_num (.clock, .en(adv), .a(t_ff),   .b(esc_pkg::PRESS_SCALE),
                        .p(num_w));

   // division operands, stage 16
   logic [63:0]       dnum_ff, dden_ff;
   esc_pkg::side_type side16_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1..4
         d1_ff      <= 32'(adc_t >> 3) - (t1 << 1);
         d2_ff      <= 32'(adc_t >> 4) - t1;
         adcp_ff[1] <= adc_p;
         adch_ff[1] <= adc_h;
         for (int i = 2; i <= 4; i++) adcp_ff[i] <= adcp_ff[i-1];
         for (int i = 2; i <= 6; i++) adch_ff[i] <= adch_ff[i-1];
         m1_ff   <= d1_ff * t2;
         m2_ff   <= d2_ff * d2_ff;
         var1_ff <= 32'($signed(m1_ff) >>> 11);
         m3_ff   <= 32'($signed(m2_ff) >>> 12) * t3;
         tf_ff   <= var1_ff + 32'($signed(m3_ff) >>> 14);
         // stage 5
         temp_ff[5] <= temp_c;
         for (int i = 6; i <= 15; i++) temp_ff[i] <= temp_ff[i-1];
         a0_ff     <= {{32{tf_ff[31]}}, tf_ff} - esc_pkg::PRESS_T_OFS;
         pn_ff[5]  <= esc_pkg::PRESS_ADC_FS - {44'b0, adcp_ff[4]};
         for (int i = 6; i <= 12; i++) pn_ff[i] <= pn_ff[i-1];
         v_ff      <= tf_ff - esc_pkg::HUM_T_OFS;
         // humidity
         mh5v_ff   <= h5 * v_ff;
         mvh3_ff   <= v_ff * h3;
         mvh6_ff   <= v_ff * h6;
         ha_ff[7]  <= ha_c;
         for (int i = 8; i <= 11; i++) ha_ff[i] <= ha_ff[i-1];
         hb_ff     <= 32'($signed(mvh3_ff) >>> 11) + esc_pkg::HUM_OFS_B;
         hc_ff     <= 32'($signed(mvh6_ff) >>> 10);
         mhb_ff    <= hc_ff * hb_ff;
         hd_ff     <= 32'($signed(mhb_ff) >>> 10) + esc_pkg::HUM_OFS_D;
         mhd_ff    <= hd_ff * h2;
         he_ff     <= 32'($signed(mhd_ff + esc_pkg::HUM_ROUND_E) >>> 14);
         x12_ff    <= ha_ff[11] * he_ff;
         mss_ff    <= s_c * s_c;
         x_ff[13]  <= x12_ff;
         x_ff[14]  <= x_ff[13];
         mt_ff     <= 32'($signed(mss_ff) >>> 7) * h1;
         hum_ff    <= xc_c[28:12];
         // pressure
         ap5_ff[8] <= ap5_w;
         ap5_ff[9] <= ap5_ff[8];
         ap2_ff[8] <= ap2_w;
         ap2_ff[9] <= ap2_ff[8];
         b_ff      <= b1_w + (ap5_ff[9] << 17) + (p4 << 35);
         a2x_ff    <= 64'($signed(c1_w) >>> 8) + (ap2_ff[9] << 12) + esc_pkg::PRESS_BIAS;
         bd_ff[11] <= b_ff;
         bd_ff[12] <= bd_ff[11];
         bigA_ff   <= 64'($signed(a3_w) >>> 33);
         t_ff      <= (pn_ff[12] << 31) - bd_ff[12];
         ad_ff[14] <= bigA_ff;
         ad_ff[15] <= ad_ff[14];
         // stage 16: magnitudes and signs for the divider
         dnum_ff         <= num_w[63] ? 64'd0 - num_w : num_w;
         dden_ff         <= ad_ff[15][63] ? 64'd0 - ad_ff[15] : ad_ff[15];
         side16_ff.temp  <= temp_ff[15];
         side16_ff.hum   <= hum_ff;
         side16_ff.azero <= (ad_ff[15] == 64'd0);
         side16_ff.negq  <= num_w[63] ^ ad_ff[15][63];
      end
   end

   logic [63:0]       quot_w;
   esc_pkg::side_type side80_w;

   esc_div u_div (
      .clock,
      .en(adv),
      .num(dnum_ff),
      .den(dden_ff),
      .side_in(side16_ff),
      .quot(quot_w),
      .side_out(side80_w)
   );

   // back end, stages 81..87
   logic [63:0]       p81_ff, qq_w, m9q_w, m8p_w, c1m_w, sum_ff;
   logic [63:0]       qq_ff [82:83];
   logic [63:0]       pd_ff [82:85];
   logic [63:0]       c2_ff [84:85];
   esc_pkg::side_type side_ff [81:86];
   logic [63:0]       pr_c;
   logic [31:0]       press_c;
   logic [15:0]       temp_out_ff;
   logic [31:0]       press_out_ff;
   logic [16:0]       hum_out_ff;
   logic              pvalid_ff;

   assign qq_w = 64'($signed(p81_ff) >>> 13);

   esc_mul64 u_mul_9q  (.clock, .en(adv), .a(qq_w),   .b(p9),        .p(m9q_w));
   esc_mul64 u_mul_8p  (.clock, .en(adv), .a(p81_ff), .b(p8),        .p(m8p_w));
   esc_mul64 u_mul_9qq (.clock, .en(adv), .a(m9q_w),  .b(qq_ff[83]), .p(c1m_w));

   always_comb begin
      pr_c = 64'($signed(sum_ff) >>> 8) + (p7 << 4);
      if (pr_c[63])
         press_c = '0;
      else if (pr_c[63:32] != 32'd0)
         press_c = 32'hFFFF_FFFF;
      else
         press_c = pr_c[31:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p81_ff      <= side80_w.negq ? 64'd0 - quot_w : quot_w;
         side_ff[81] <= side80_w;
         for (int i = 82; i <= 86; i++) side_ff[i] <= side_ff[i-1];
         qq_ff[82]   <= qq_w;
         qq_ff[83]   <= qq_ff[82];
         pd_ff[82]   <= p81_ff;
         for (int i = 83; i <= 85; i++) pd_ff[i] <= pd_ff[i-1];
         c2_ff[84]   <= m8p_w;
         c2_ff[85]   <= c2_ff[84];
         sum_ff      <= pd_ff[85] + 64'($signed(c1m_w) >>> 25)
                        + 64'($signed(c2_ff[85]) >>> 19);
         // output word, zero pressure when the divisor was zero
         temp_out_ff  <= side_ff[86].temp;
         hum_out_ff   <= side_ff[86].hum;
         pvalid_ff    <= !side_ff[86].azero;
         press_out_ff <= side_ff[86].azero ? 32'd0 : press_c;
      end
   end

   assign rsp_tdata = {7'b0, hum_out_ff, press_out_ff, temp_out_ff};
   assign rsp_tuser = pvalid_ff;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [15:0] temp;
      logic [31:0] press;
      logic        pvalid;
      logic [16:0] hum;
   } sample_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   logic [47:0] cal_temp_q;
   logic [63:0] cal_press_a_q;
   logic [63:0] cal_press_b_q;
   logic [47:0] cal_mixed_q;
   logic [31:0] cal_hum_q;

   sample_result_type expected_results[$];
   int error_count;
   int idle_cycles;
   bit receiver_hold;
   bit stall_burst_mode;

   env_sensor_compensation_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic signed [31:0] asr32(logic signed [31:0] x, int n);
      return x >>> n;
   endfunction

   function automatic sample_result_type compensate(logic [19:0] adc_p, logic [19:0] adc_t,
                                                    logic [15:0] adc_h);
      sample_result_type r;
      logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [31:0] d1, d2, var1, var2, tfine, tc;
      logic signed [63:0] a, b, p, q, c1, c2, num, ma, mb, qu;
      logic signed [31:0] v, ha, hb, hc, hd, he, x, s;
      t1 = {16'd0, cal_temp_q[15:0]};
      t2 = {{16{cal_temp_q[31]}}, cal_temp_q[31:16]};
      t3 = {{16{cal_temp_q[47]}}, cal_temp_q[47:32]};
      p1 = {48'd0, cal_press_a_q[15:0]};
      p2 = {{48{cal_press_a_q[31]}}, cal_press_a_q[31:16]};
      p3 = {{48{cal_press_a_q[47]}}, cal_press_a_q[47:32]};
      p4 = {{48{cal_press_a_q[63]}}, cal_press_a_q[63:48]};
      p5 = {{48{cal_press_b_q[15]}}, cal_press_b_q[15:0]};
      p6 = {{48{cal_press_b_q[31]}}, cal_press_b_q[31:16]};
      p7 = {{48{cal_press_b_q[47]}}, cal_press_b_q[47:32]};
      p8 = {{48{cal_press_b_q[63]}}, cal_press_b_q[63:48]};
      p9 = {{48{cal_mixed_q[15]}}, cal_mixed_q[15:0]};
      h1 = {24'd0, cal_mixed_q[23:16]};
      h2 = {{16{cal_mixed_q[39]}}, cal_mixed_q[39:24]};
      h3 = {24'd0, cal_mixed_q[47:40]};
      h4 = {{20{cal_hum_q[11]}}, cal_hum_q[11:0]};
      h5 = {{20{cal_hum_q[23]}}, cal_hum_q[23:12]};
      h6 = {{24{cal_hum_q[31]}}, cal_hum_q[31:24]};

      d1 = {15'd0, adc_t[19:3]} - (t1 << 1);
      var1 = asr32(d1 * t2, 11);
      d2 = {16'd0, adc_t[19:4]} - t1;
      var2 = asr32(asr32(d2 * d2, 12) * t3, 14);
      tfine = var1 + var2;
      tc = asr32(tfine * 5 + 128, 8);
      if (tc < -32768) r.temp = 16'h8000;
      else if (tc > 32767) r.temp = 16'h7fff;
      else r.temp = tc[15:0];

      a = 64'(tfine) - 64'sd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) << 12);
      a = (((64'sd1 << 47) + a) * p1) >>> 33;
      r.press = '0;
      r.pvalid = 1'b0;
      if (a != 0) begin
         p = 64'sd1048576 - {44'd0, adc_p};
         num = ((p << 31) - b) * 64'sd3125;
         ma = num[63] ? -num : num;
         mb = a[63] ? -a : a;
         qu = $signed(64'($unsigned(ma) / $unsigned(mb)));
         p = (num[63] != a[63]) ? -qu : qu;
         q = p >>> 13;
         c1 = (p9 * q * q) >>> 25;
         c2 = (p8 * p) >>> 19;
         p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
         r.pvalid = 1'b1;
         if (p < 0) r.press = '0;
         else if (p > 64'sh0ffff_ffff) r.press = 32'hffff_ffff;
         else r.press = p[31:0];
      end

      v = tfine - 32'sd76800;
      ha = ({16'd0, adc_h} << 14) - (h4 << 20) - h5 * v;
      ha = asr32(ha + 32'sd16384, 15);
      hb = asr32(v * h3, 11) + 32'sd32768;
      hc = asr32(v * h6, 10);
      hd = asr32(hc * hb, 10) + 32'sd2097152;
      he = asr32(hd * h2 + 32'sd8192, 14);
      x = ha * he;
      s = asr32(x, 15);
      x = x - asr32(asr32(s * s, 7) * h1, 4);
      if (x < 0) x = 0;
      if (x > 32'sd419430400) x = 32'sd419430400;
      r.hum = x[28:12];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // check result words at the rising edge
   always @(posedge clock) begin
      sample_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[31:0], 32'd0);
         end else begin
            e = expected_results.pop_front();
            if (rsp_tdata[15:0] !== e.temp)
               report_mismatch("temperature", rsp_tdata[15:0], e.temp);
            if (rsp_tdata[47:16] !== e.press)
               report_mismatch("pressure", rsp_tdata[47:16], e.press);
            if (rsp_tdata[64:48] !== e.hum)
               report_mismatch("humidity", rsp_tdata[64:48], e.hum);
            if (rsp_tuser !== e.pvalid)
               report_mismatch("pressure_valid", rsp_tuser, e.pvalid);
         end
      end
   end

   // watchdog on accept activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int k;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_hold) begin
            rsp_tready <= 1'b0;
            for (k = 0; k < 400; k++) @(negedge clock);
            receiver_hold = 1'b0;
         end else if (stall_burst_mode) begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(esc_pkg::csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         esc_pkg::CSR_CAL_TEMP:    cal_temp_q = value[47:0];
         esc_pkg::CSR_CAL_PRESS_A: cal_press_a_q = value;
         esc_pkg::CSR_CAL_PRESS_B: cal_press_b_q = value;
         esc_pkg::CSR_CAL_MIXED:   cal_mixed_q = value[47:0];
         esc_pkg::CSR_CAL_HUM:     cal_hum_q = value[31:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all_csr(logic [47:0] ct, logic [63:0] pa, logic [63:0] pb,
                                logic [47:0] cm, logic [31:0] ch);
      write_csr(esc_pkg::CSR_CAL_TEMP, {16'd0, ct});
      write_csr(esc_pkg::CSR_CAL_PRESS_A, pa);
      write_csr(esc_pkg::CSR_CAL_PRESS_B, pb);
      write_csr(esc_pkg::CSR_CAL_MIXED, {16'd0, cm});
      write_csr(esc_pkg::CSR_CAL_HUM, {32'd0, ch});
   endtask

   task automatic drain();
      int k;
      while (expected_results.size() != 0) @(negedge clock);
      for (k = 0; k < 100; k++) @(negedge clock);
   endtask

   // offer one word and hold it until accepted; push expectation unless given
   task automatic send_sample(logic [19:0] ap, logic [19:0] at, logic [15:0] ah,
                              bit use_given, sample_result_type given);
      req_tvalid <= 1'b1;
      req_tdata <= {ah, at, ap};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(use_given ? given : compensate(ap, at, ah));
      @(negedge clock);
   endtask

   task automatic send_random(int count, bit gaps);
      int n, burst, k, gap;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 30);
         for (k = 0; k < burst && n < count; k++) begin
            send_sample(20'($urandom), 20'($urandom), 16'($urandom), 1'b0, '{default: '0});
            n++;
         end
         gap = gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0 && n < count) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   // typical datasheet-like calibration set
   localparam logic [47:0] TYPICAL_TEMP = {16'd50, 16'd26435, 16'd27504};
   localparam logic [63:0] TYPICAL_PA = {16'd2855, 16'd3024, 16'hd5b6, 16'd36477};
   localparam logic [63:0] TYPICAL_PB = {16'hfc18, 16'd15500, 16'hfff9, 16'd140};
   localparam logic [47:0] TYPICAL_MIXED = {8'd0, 16'd361, 8'd75, 16'd6000};
   localparam logic [31:0] TYPICAL_HUM = {8'd30, 12'd50, 12'd313};

   typedef struct {
      logic [19:0] ap;
      logic [19:0] at;
      logic [15:0] ah;
      bit          fixed;
   } stim_row_type;

   initial begin
      stim_row_type rows[$];
      sample_result_type zero_result;
      int phase;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = esc_pkg::CSR_CAL_TEMP;
      csr_wdata = '0;
      cal_temp_q = '0;
      cal_press_a_q = '0;
      cal_press_b_q = '0;
      cal_mixed_q = '0;
      cal_hum_q = '0;
      error_count = 0;
      idle_cycles = 0;
      receiver_hold = 1'b0;
      stall_burst_mode = 1'b0;
      zero_result = '{temp: 16'd0, press: 32'd0, pvalid: 1'b0, hum: 17'd0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all-zero calibration: every field zero, pressure divisor zero
      rows = '{'{20'h0, 20'h0, 16'h0, 1'b1}, '{20'hfffff, 20'hfffff, 16'hffff, 1'b1},
               '{20'h80000, 20'h7ffff, 16'h8000, 1'b1}};
      foreach (rows[i])
         send_sample(rows[i].ap, rows[i].at, rows[i].ah, rows[i].fixed, zero_result);
      req_tvalid <= 1'b0;
      drain();

      write_all_csr(TYPICAL_TEMP, TYPICAL_PA, TYPICAL_PB, TYPICAL_MIXED, TYPICAL_HUM);
      rows = '{'{20'd415148, 20'd519888, 16'd30000, 1'b0},
               '{20'h0, 20'h0, 16'h0, 1'b0}, '{20'hfffff, 20'hfffff, 16'hffff, 1'b0},
               '{20'h0, 20'hfffff, 16'h0, 1'b0}, '{20'hfffff, 20'h0, 16'hffff, 1'b0},
               '{20'h55555, 20'haaaaa, 16'h5555, 1'b0},
               '{20'haaaaa, 20'h55555, 16'haaaa, 1'b0}};
      foreach (rows[i])
         send_sample(rows[i].ap, rows[i].at, rows[i].ah, rows[i].fixed, zero_result);
      req_tvalid <= 1'b0;
      drain();

      // extremes: saturation of temperature, pressure, humidity clamps
      write_all_csr({16'h7fff, 16'h7fff, 16'h0000}, {16'h7fff, 16'h7fff, 16'h7fff, 16'hffff},
                    {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 48'hff7fffff7fff,
                    32'h7f7ff7ff);
      rows = '{'{20'h0, 20'hfffff, 16'hffff, 1'b0}, '{20'hfffff, 20'h0, 16'h0, 1'b0},
               '{20'h12345, 20'h80000, 16'h8000, 1'b0}};
      foreach (rows[i])
         send_sample(rows[i].ap, rows[i].at, rows[i].ah, rows[i].fixed, zero_result);
      req_tvalid <= 1'b0;
      drain();
      write_all_csr(48'hffff_8000_8000, 64'h8000_8000_8000_0001, 64'h8000_8000_8000_8000,
                    48'h00_8000_00_8000, 32'h80800800);
      rows = '{'{20'h0, 20'hfffff, 16'hffff, 1'b0}, '{20'hfffff, 20'h0, 16'h0, 1'b0}};
      foreach (rows[i])
         send_sample(rows[i].ap, rows[i].at, rows[i].ah, rows[i].fixed, zero_result);
      req_tvalid <= 1'b0;
      drain();

      // random phases with fresh calibration; typical and fully random sets
      stall_burst_mode = 1'b1;
      for (phase = 0; phase < 8; phase++) begin
         if (phase % 2 == 0)
            write_all_csr(TYPICAL_TEMP ^ {32'd0, 16'($urandom_range(0, 255))},
                          TYPICAL_PA, TYPICAL_PB ^ 64'($urandom_range(0, 63)),
                          TYPICAL_MIXED, TYPICAL_HUM);
         else
            write_all_csr(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 48'({$urandom, $urandom}), $urandom);
         if (phase == 3) begin
            // long receiver hold while the sender keeps offering
            receiver_hold = 1'b1;
            send_random(200, 1'b0);
         end else begin
            send_random(100, phase != 5);
         end
         drain();
      end
      stall_burst_mode = 1'b0;
      send_random(135, 1'b1);

      while (expected_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/esc_pkg.sv
rtl/core/esc_mul64.sv
rtl/core/esc_div.sv
rtl/core/env_sensor_compensation_top.sv
verif/testbench.sv
